@@ hw/rtl/pfa_pkg.sv @@
// shared types and constants for the partition fit allocator
package pfa_pkg;

    localparam int PARTITIONS = 16;
    localparam int IDX_W      = $clog2(PARTITIONS);
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int ADDR_W     = 3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    localparam logic [1:0]         FIT_MODE_RST   = FIT_FIRST;
    localparam logic [COUNT_W-1:0] PART_COUNT_RST = COUNT_W'(PARTITIONS);

    typedef struct packed {
        logic              kind;
        logic [3:0]        partition_index;
        logic [SIZE_W-1:0] block_size;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic [3:0]        chosen_index;
        logic [SIZE_W-1:0] chosen_size;
    } t_out_item;

endpackage

@@ hw/rtl/partition_fit_allocator.sv @@
// partition fit allocator top level
// A load beat writes the partition's size into the size memory. For a request beat the scan
// reads the single-port size memory one partition per cycle, the read data is compared in the
// next cycle, and a final done state writes back a first fit pick's remaining size or marks
// a best or worst fit pick used, and registers the result. First fit stops the scan at the first
// partition that fits. A mode of 3 or a partition count of zero answers with no grant. Partitions
// never loaded read as remaining size zero and are never chosen. The next input beat is taken as
// soon as the result sits in the output register, while it waits for the consumer; a result still
// held there stalls the final done state of the next request.
module partition_fit_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pfa_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pfa_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfa_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import pfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [1:0]              r_fit_mode;
    logic [COUNT_W-1:0]      r_part_count;

    logic [2*SIZE_W-1:0]     r_mem [PARTITIONS];
    logic [2*SIZE_W-1:0]     r_rdata;
    logic [PARTITIONS-1:0]   r_rem_vld;
    logic [PARTITIONS-1:0]   r_used;

    logic [SIZE_W-1:0]       r_req;
    logic [1:0]              r_mode;
    logic [COUNT_W-1:0]      r_cnt;
    logic [COUNT_W-1:0]      r_addr;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_found;
    logic [IDX_W-1:0]        r_pick;
    logic [SIZE_W-1:0]       r_pick_org;
    logic [SIZE_W-1:0]       r_pick_left;

    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_acc;
    logic                    cfg_wr;
    logic [COUNT_W-1:0]      eff_count;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [2*SIZE_W-1:0]     mem_wdata;
    logic                    mem_re;
    logic [SIZE_W-1:0]       cur_rem;
    logic                    cur_fits;
    logic [SIZE_W-1:0]       cur_left;
    logic                    cur_better;
    logic                    scan_last;
    logic                    out_free;
    logic                    load_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_PART_COUNT) ? {{(32-COUNT_W){1'b0}}, r_part_count}
                                                      : {30'd0, r_fit_mode};

    assign eff_count = (r_part_count > COUNT_W'(PARTITIONS)) ? COUNT_W'(PARTITIONS)
                                                             : r_part_count;
    assign load_ok   = 32'(i_in_data.partition_index) < PARTITIONS;
    assign out_free  = !r_out_valid || i_out_ready;

    // scan compare on the data read in the previous cycle
    assign cur_rem    = r_rem_vld[r_rd_idx] ? r_rdata[SIZE_W-1:0] : '0;
    assign cur_fits   = cur_rem > r_req;
    assign cur_left   = cur_rem - r_req;
    assign cur_better = (r_mode == FIT_WORST) ? (cur_left > r_pick_left)
                                              : (cur_left < r_pick_left);
    assign scan_last  = ({1'b0, r_rd_idx} == COUNT_W'(r_cnt - 1'b1));
    assign mem_re     = (r_state == S_SCAN) && (r_addr < r_cnt);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(i_in_data.partition_index);
        mem_wdata = {i_in_data.block_size, i_in_data.block_size};
        if (in_acc && i_in_data.kind == KIND_LOAD && load_ok) begin
            mem_we = 1'b1;
        end else if (r_state == S_DONE && out_free && r_found && r_mode == FIT_FIRST) begin
            mem_we    = 1'b1;
            mem_waddr = r_pick;
            mem_wdata = {r_pick_org, r_pick_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_mode   <= FIT_MODE_RST;
            r_part_count <= PART_COUNT_RST;
            r_rem_vld    <= '0;
            r_used       <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_FIT_MODE) begin
                    r_fit_mode <= pwdata[1:0];
                end else begin
                    r_part_count <= pwdata[COUNT_W-1:0];
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.kind == KIND_LOAD) begin
                            if (load_ok) begin
                                r_rem_vld[IDX_W'(i_in_data.partition_index)] <= 1'b1;
                                r_used[IDX_W'(i_in_data.partition_index)]    <= 1'b0;
                            end
                        end else begin
                            r_req    <= i_in_data.block_size;
                            r_mode   <= r_fit_mode;
                            r_cnt    <= eff_count;
                            r_addr   <= '0;
                            r_rd_vld <= 1'b0;
                            r_found  <= 1'b0;
                            if (eff_count == '0 || (r_fit_mode != FIT_FIRST &&
                                    r_fit_mode != FIT_BEST && r_fit_mode != FIT_WORST)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= mem_re;
                    r_rd_idx <= r_addr[IDX_W-1:0];
                    if (mem_re) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (r_mode == FIT_FIRST) begin
                            if (cur_fits) begin
                                r_found     <= 1'b1;
                                r_pick      <= r_rd_idx;
                                r_pick_org  <= r_rdata[2*SIZE_W-1:SIZE_W];
                                r_pick_left <= cur_left;
                            end
                        end else if (cur_fits && !r_used[r_rd_idx]
                                && (!r_found || cur_better)) begin
                            r_found     <= 1'b1;
                            r_pick      <= r_rd_idx;
                            r_pick_org  <= r_rdata[2*SIZE_W-1:SIZE_W];
                            r_pick_left <= cur_left;
                        end
                        if (scan_last || (r_mode == FIT_FIRST && cur_fits)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_rd_vld <= 1'b0;
                    if (out_free) begin
                        if (r_found) begin
                            r_out.granted      <= 1'b1;
                            r_out.chosen_index <= 4'(r_pick);
                            r_out.chosen_size  <= r_pick_org;
                            if (r_mode != FIT_FIRST) begin
                                r_used[r_pick] <= 1'b1;
                            end
                        end else begin
                            r_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/pfa_checker.sv @@
// port-level checks for the partition fit allocator, bound to the top level
module pfa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input pfa_pkg::t_in_item          i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input pfa_pkg::t_out_item         o_out_data,
    input logic                       pready
);

    // a beat not taken holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // refusal carries zero index and zero size
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.granted |->
            o_out_data.chosen_index == 4'd0 && o_out_data.chosen_size == 16'd0)
        else $error("refusal with nonzero payload");

    // a request closes the input side in the cycle after it is taken
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == pfa_pkg::KIND_REQUEST |=> !o_in_ready)
        else $error("input open right after a request");

    // no result without a request before it
    a_out_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while idle");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);
